[sv/sbur_pkg.sv]
// Shared types, constants and helpers for the seismic block datagram repacker.
`default_nettype none
package sbur_pkg;

  localparam int STORE_BYTES = 2048;
  localparam int OFF_W       = $clog2(STORE_BYTES);
  localparam int OFS_W       = 12;
  localparam int QDEPTH      = 4;
  localparam int QAW         = $clog2(QDEPTH);
  localparam int RUN_BYTES   = 10;
  localparam int CNT_W       = 4;

  localparam logic [7:0]  PACKET_ID     = 8'hA0;
  localparam logic [10:0] MAX_SEG_RESET = 11'd1472;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
    logic       end_of_data;
  } req_t;

  typedef struct packed {
    logic       push_taken;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       out_last;
    logic       block_dropped;
  } rsp_t;

  // One queued piece of store work plus the result it ends with.
  typedef struct packed {
    logic                   push_taken;
    logic                   block_dropped;
    logic                   rd_en;
    logic                   rd_last;
    logic                   rd_half;
    logic [OFF_W-1:0]       rd_off;
    logic [CNT_W-1:0]       n_wr;
    logic [CNT_W-1:0]       main_cnt;
    logic                   main_half;
    logic [OFF_W-1:0]       main_off;
    logic [8*RUN_BYTES-1:0] main_data;
    logic                   sz_en;
    logic [OFF_W-1:0]       sz_off;
    logic [15:0]            sz_data;
    logic                   fin_en;
    logic                   fin_half;
    logic [7:0]             fin_pkt;
  } job_t;

  function automatic logic [OFF_W-1:0] store_off(input logic [OFS_W-1:0] o);
    logic [OFF_W+OFS_W-1:0] t;
    t = {{OFF_W{1'b0}}, o};
    return t[OFF_W-1:0];
  endfunction

endpackage
`default_nettype wire

[sv/sbur_front.sv]
// Front part: parses requests, keeps the parsing and payload state, emits store jobs.
`default_nettype none
module sbur_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire sbur_pkg::req_t    req,
  input  wire logic              cfg_we,
  input  wire logic [10:0]       cfg_wdata,
  output logic                   q_push,
  output sbur_pkg::job_t         q_job,
  input  wire logic              q_full
);

  typedef enum logic [2:0] {
    PH_SIZE, PH_WHOLE, PH_STAMP, PH_CHHDR, PH_CHBODY, PH_SKIP
  } phase_t;

  phase_t      phase, phase_next;
  logic [10:0] max_seg;
  logic        half, half_next;
  logic [11:0] wo, wo_next, sfo, sfo_next, doff, doff_next, dlen, dlen_next;
  logic [7:0]  pkt, pkt_next;
  logic [31:0] hc, hc_next, br, br_next, br_dec;
  logic [2:0]  cc, cc_next;
  logic [15:0] cr, cr_next, cr_dec;
  logic        first, first_next;
  logic [47:0] ts, ts_next;

  logic        acc, eod;
  logic [7:0]  b;
  logic [31:0] gh, len2;
  logic [11:0] sr;
  logic [3:0]  code;
  logic [15:0] prod, gs, gs4, part;
  logic        too_big, ch_flush, end_flush, refuse, new_part;
  logic [12:0] w1;
  logic [17:0] need;
  logic [11:0] base_wo, base_sfo, sfo_eff, wo_after;
  logic        half_eff;
  sbur_pkg::job_t job;

  assign req_ready = !q_full;
  assign acc       = req_valid && !q_full;
  assign q_push    = acc;
  assign q_job     = job;

  assign b    = req.data_byte;
  assign eod  = req.end_of_data;
  assign gh   = {hc[23:0], b};
  assign sr   = gh[11:0];
  assign code = gh[15:12];
  assign prod = 16'(code) * 16'(sr - 12'd1);
  assign gs   = (code == 4'd0) ? (16'(sr >> 1) + 16'd8) :
                (sr == 12'd0) ? 16'd4 : (prod + 16'd8);
  assign gs4  = gs - 16'd4;
  assign too_big = (17'(gs) + 17'd11) > 17'(max_seg);
  assign w1   = 13'(wo) + ((phase == PH_WHOLE || phase == PH_CHBODY) ? 13'd1 : 13'd0);
  assign need = 18'(wo) + 18'(gs) + (first ? 18'd8 : 18'd0);
  assign ch_flush  = (phase == PH_CHHDR) && (cc == 3'd3) && !eod && !too_big &&
                     (need > 18'(max_seg));
  assign end_flush = eod && (w1 > 13'd11);
  assign refuse    = (ch_flush || end_flush) && (dlen != 12'd0);
  assign br_dec    = (br != 32'd0) ? br - 32'd1 : 32'd0;
  assign cr_dec    = (cr != 16'd0) ? cr - 16'd1 : 16'd0;
  assign len2      = gh - 32'd2;
  assign new_part  = ch_flush || first;
  assign base_wo   = ch_flush ? 12'd3 : wo;
  assign base_sfo  = ch_flush ? 12'd3 : sfo;
  assign half_eff  = ch_flush ? ~half : half;
  assign sfo_eff   = new_part ? base_wo : base_sfo;
  assign wo_after  = base_wo + (new_part ? 12'd12 : 12'd4);
  assign part      = 16'(wo_after) + gs4 - 16'(sfo_eff);

  always_comb begin
    phase_next = phase;
    half_next  = half;
    wo_next    = wo;
    sfo_next   = sfo;
    doff_next  = doff;
    dlen_next  = dlen;
    pkt_next   = pkt;
    hc_next    = hc;
    br_next    = br;
    cc_next    = cc;
    cr_next    = cr;
    first_next = first;
    ts_next    = ts;
    job        = '0;
    job.main_half = half;
    if (acc) begin
      if (req.command) begin
        if (dlen != 12'd0) begin
          job.rd_en   = 1'b1;
          job.rd_half = ~half;
          job.rd_off  = sbur_pkg::store_off(doff);
          doff_next   = doff + 12'd1;
          if ((13'(doff) + 13'd1) >= 13'(dlen)) begin
            job.rd_last = 1'b1;
            doff_next   = 12'd0;
            dlen_next   = 12'd0;
          end
        end
      end else if (!refuse) begin
        job.push_taken = 1'b1;
        unique case (phase)
          PH_SIZE: begin
            hc_next = gh;
            cc_next = cc + 3'd1;
            if (cc == 3'd3) begin
              cc_next = 3'd0;
              if (!eod && gh >= 32'd4) begin
                br_next = gh - 32'd4;
                if ((33'(wo) + 33'(len2)) <= 33'(max_seg)) begin
                  job.main_cnt  = 4'd2;
                  job.main_off  = sbur_pkg::store_off(wo);
                  job.main_data = {len2[15:0], 64'd0};
                  wo_next       = wo + 12'd2;
                  phase_next    = (gh != 32'd4) ? PH_WHOLE : PH_SIZE;
                end else begin
                  phase_next = PH_STAMP;
                  first_next = 1'b1;
                  ts_next    = 48'd0;
                end
              end
            end
          end
          PH_WHOLE: begin
            job.main_cnt  = 4'd1;
            job.main_off  = sbur_pkg::store_off(wo);
            job.main_data = {b, 72'd0};
            wo_next       = wo + 12'd1;
            br_next       = br_dec;
            if (br_dec == 32'd0) phase_next = PH_SIZE;
          end
          PH_STAMP: begin
            ts_next = {ts[39:0], b};
            br_next = br_dec;
            cc_next = cc + 3'd1;
            if (cc == 3'd5) begin
              cc_next    = 3'd0;
              phase_next = (br_dec != 32'd0) ? PH_CHHDR : PH_SIZE;
            end
          end
          PH_CHHDR: begin
            hc_next = gh;
            br_next = br_dec;
            cc_next = cc + 3'd1;
            if (cc == 3'd3 && !eod) begin
              cc_next = 3'd0;
              cr_next = gs4;
              if (too_big) begin
                job.block_dropped = 1'b1;
                phase_next = (gs4 != 16'd0) ? PH_SKIP :
                             (br_dec != 32'd0) ? PH_CHHDR : PH_SIZE;
              end else begin
                if (ch_flush) begin
                  job.fin_en   = 1'b1;
                  job.fin_half = half;
                  job.fin_pkt  = pkt;
                  dlen_next    = wo;
                  doff_next    = 12'd0;
                  half_next    = ~half;
                  pkt_next     = pkt + 8'd1;
                end
                job.main_half = half_eff;
                if (new_part) begin
                  job.main_cnt  = 4'd10;
                  job.main_off  = sbur_pkg::store_off(base_wo + 12'd2);
                  job.main_data = {ts, gh};
                  first_next    = 1'b0;
                end else begin
                  job.main_cnt  = 4'd4;
                  job.main_off  = sbur_pkg::store_off(base_wo);
                  job.main_data = {gh, 48'd0};
                end
                job.sz_en   = 1'b1;
                job.sz_off  = sbur_pkg::store_off(sfo_eff);
                job.sz_data = part;
                sfo_next    = sfo_eff;
                wo_next     = wo_after;
                phase_next  = (gs4 != 16'd0) ? PH_CHBODY :
                              (br_dec != 32'd0) ? PH_CHHDR : PH_SIZE;
              end
            end
          end
          PH_CHBODY: begin
            job.main_cnt  = 4'd1;
            job.main_off  = sbur_pkg::store_off(wo);
            job.main_data = {b, 72'd0};
            wo_next       = wo + 12'd1;
            br_next       = br_dec;
            cr_next       = cr - 16'd1;
            if (cr == 16'd1) phase_next = (br_dec != 32'd0) ? PH_CHHDR : PH_SIZE;
          end
          PH_SKIP: begin
            br_next = br_dec;
            cr_next = cr_dec;
            if (cr_dec == 16'd0) phase_next = (br_dec != 32'd0) ? PH_CHHDR : PH_SIZE;
          end
          default: ;
        endcase
        if (eod) begin
          phase_next = PH_SIZE;
          cc_next    = 3'd0;
          hc_next    = 32'd0;
          br_next    = 32'd0;
          cr_next    = 16'd0;
          first_next = 1'b1;
          if (wo_next > 12'd11) begin
            job.fin_en   = 1'b1;
            job.fin_half = half;
            job.fin_pkt  = pkt;
            dlen_next    = wo_next;
            doff_next    = 12'd0;
            half_next    = ~half;
          end
          wo_next  = 12'd3;
          sfo_next = 12'd3;
          pkt_next = 8'd0;
        end
      end
    end
    job.n_wr = job.main_cnt + (job.sz_en ? 4'd2 : 4'd0) + (job.fin_en ? 4'd3 : 4'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_SIZE;
      max_seg <= sbur_pkg::MAX_SEG_RESET;
      half    <= 1'b0;
      wo      <= 12'd3;
      sfo     <= 12'd3;
      doff    <= 12'd0;
      dlen    <= 12'd0;
      pkt     <= 8'd0;
      hc      <= 32'd0;
      br      <= 32'd0;
      cc      <= 3'd0;
      cr      <= 16'd0;
      first   <= 1'b1;
      ts      <= 48'd0;
    end else begin
      phase <= phase_next;
      if (cfg_we) max_seg <= cfg_wdata;
      half  <= half_next;
      wo    <= wo_next;
      sfo   <= sfo_next;
      doff  <= doff_next;
      dlen  <= dlen_next;
      pkt   <= pkt_next;
      hc    <= hc_next;
      br    <= br_next;
      cc    <= cc_next;
      cr    <= cr_next;
      first <= first_next;
      ts    <= ts_next;
    end
  end

endmodule
`default_nettype wire

[sv/sbur_queue.sv]
// Short job queue between the front and back parts.
`default_nettype none
module sbur_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire sbur_pkg::job_t  din,
  output logic                 full,
  output logic                 valid,
  output sbur_pkg::job_t       dout,
  input  wire logic            pop
);

  sbur_pkg::job_t              ent [sbur_pkg::QDEPTH];
  logic [sbur_pkg::QAW-1:0]    wptr, rptr;
  logic [sbur_pkg::QAW:0]      cnt;

  assign full  = (cnt == (sbur_pkg::QAW+1)'(sbur_pkg::QDEPTH));
  assign valid = (cnt != '0);
  assign dout  = ent[rptr];

  always_ff @(posedge clk) begin
    if (push) ent[wptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      cnt <= cnt + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end

endmodule
`default_nettype wire

[sv/sbur_back.sv]
// Back part: payload store, one write or read per cycle unless stalled, result register.
`default_nettype none
module sbur_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire sbur_pkg::job_t  q_job,
  output logic                 q_pop,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  output sbur_pkg::rsp_t       rsp
);

  localparam int MAW = sbur_pkg::OFF_W + 1;

  logic [7:0]                   mem [2*sbur_pkg::STORE_BYTES];
  logic [7:0]                   rdata;
  logic [sbur_pkg::CNT_W-1:0]   k, j, f;
  logic                         last_step, slot_free, fire, we, re;
  logic [MAW-1:0]               waddr, raddr;
  logic [7:0]                   wdata;
  logic [8*sbur_pkg::RUN_BYTES-1:0] mshift;
  logic                         r_taken, r_drop, r_valid, r_last;

  assign last_step = (q_job.n_wr == '0) || (k == q_job.n_wr - 1'b1);
  assign slot_free = !rsp_valid || rsp_ready;
  assign fire      = q_valid && (!last_step || slot_free);
  assign q_pop     = q_valid && last_step && slot_free;
  assign we        = fire && (q_job.n_wr != '0);
  assign re        = q_pop && q_job.rd_en;
  assign raddr     = {q_job.rd_half, q_job.rd_off};
  assign mshift    = q_job.main_data << {k, 3'b000};
  assign j         = k - q_job.main_cnt;
  assign f         = j - (q_job.sz_en ? 4'd2 : 4'd0);

  // byte k of the job: main run, then size field, then payload head
  always_comb begin
    if (k < q_job.main_cnt) begin
      waddr = {q_job.main_half, q_job.main_off + sbur_pkg::OFF_W'(k)};
      wdata = mshift[8*sbur_pkg::RUN_BYTES-1 -: 8];
    end else if (q_job.sz_en && j < 4'd2) begin
      waddr = {q_job.main_half, q_job.sz_off + sbur_pkg::OFF_W'(j)};
      wdata = (j == 4'd0) ? q_job.sz_data[15:8] : q_job.sz_data[7:0];
    end else begin
      waddr = {q_job.fin_half, sbur_pkg::OFF_W'(f)};
      wdata = (f == 4'd2) ? sbur_pkg::PACKET_ID : q_job.fin_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      r_taken <= q_job.push_taken;
      r_drop  <= q_job.block_dropped;
      r_valid <= q_job.rd_en;
      r_last  <= q_job.rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (fire) k <= last_step ? '0 : k + 1'b1;
      if (q_pop) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  assign rsp.push_taken    = r_taken;
  assign rsp.out_valid     = r_valid;
  assign rsp.out_byte      = r_valid ? rdata : 8'd0;
  assign rsp.out_last      = r_last;
  assign rsp.block_dropped = r_drop;

endmodule
`default_nettype wire

[sv/seismic_block_udp_repacketizer.sv]
// Top level of the seismic block datagram repacker.
// Request channel (req_valid/req_ready/req): each request pushes one raw
// stream byte or pops one finished payload byte. Response channel
// (rsp_valid/rsp_ready/rsp): exactly one response per request, in order.
// cfg_we/cfg_wdata set the segment limit; write only while idle.
// The front part decides each request in the cycle it is taken and queues
// the store work (4-entry queue); the back part does one store access per
// cycle unless a stalled response holds it. A plain data byte, a pop or a
// header byte that writes nothing takes a single back step, so such
// requests stream at one per cycle while responses are taken. A block size
// that fits whole writes 2 store bytes, a channel header 6, or up to 15
// when it opens a new part (10 header bytes, 2 size bytes, 3 payload head
// bytes), and an end of data flush adds 3. The queue hides short bursts;
// after a longer one req_ready drops until the back part catches up.
// Each response is registered when the last store step of its job is done.
// Reset clears parsing state, counters and the queue; store contents are
// not cleared and are only read after being written.
// A stalled receiver holds the response register; the queue keeps taking
// requests until it fills, then req_ready drops.
`default_nettype none
module seismic_block_udp_repacketizer (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire sbur_pkg::req_t  req,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  output sbur_pkg::rsp_t       rsp,
  input  wire logic            cfg_we,
  input  wire logic [10:0]     cfg_wdata
);

  logic           q_push, q_full, q_valid, q_pop;
  sbur_pkg::job_t q_in, q_out;

  sbur_front u_front (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .q_push(q_push), .q_job(q_in), .q_full(q_full)
  );

  sbur_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .din(q_in), .full(q_full),
    .valid(q_valid), .dout(q_out), .pop(q_pop)
  );

  sbur_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_job(q_out), .q_pop(q_pop),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

endmodule
`default_nettype wire

[sv/sbur_checker.sv]
// Port-level checks for the repacker and their bind to the top level.
`default_nettype none
module sbur_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            rsp_valid,
  input wire logic            rsp_ready,
  input wire sbur_pkg::rsp_t  rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response dropped or changed while stalled");

  a_push_or_pop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.push_taken && rsp.out_valid))
    else $error("response both takes a push and returns a byte");

  a_last_has_byte: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.out_last |-> rsp.out_valid)
    else $error("payload end without a byte");

  a_drop_on_push: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.block_dropped |-> rsp.push_taken)
    else $error("drop flagged on a refused push or pop");

  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response right after reset");

endmodule

bind seismic_block_udp_repacketizer sbur_checker u_sbur_checker (
  .clk(clk), .rst(rst), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);
`default_nettype wire

[bench/seismic_block_udp_repacketizer_tb.sv]
// Testbench for the seismic block datagram repacker: directed and random push/pop traffic checked against a predictor.
`default_nettype none
module seismic_block_udp_repacketizer_tb;

  localparam int SB = 2048;
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;
  typedef enum logic [2:0] {
    PH_SIZE, PH_WHOLE, PH_STAMP, PH_CHHDR, PH_CHBODY, PH_SKIP
  } phase_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  sbur_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  sbur_pkg::rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;

  seismic_block_udp_repacketizer dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [7:0] pstore [0:2*SB-1];
  logic [10:0] seg_limit;
  bit half;
  int unsigned wr_off, sz_off, pkt_num, coll_cnt, blk_left, ch_left, drn_off, drn_len;
  phase_e phase;
  logic [31:0] hdr;
  bit first_ch;
  logic [47:0] stamp;

  sbur_pkg::req_t pending_reqs[$];
  sbur_pkg::rsp_t expected_rsps[$];
  int errors = 0;
  int send_idle = 34, recv_idle = 82;
  bit hold_send = 1'b0;
  longint cycles = 0;

  function automatic void put(int unsigned off, int unsigned v);
    pstore[(half ? SB : 0) + (off % SB)] = v[7:0];
  endfunction

  function automatic void close_payload();
    put(0, pkt_num); put(1, pkt_num); put(2, sbur_pkg::PACKET_ID);
    drn_len = wr_off & 12'hfff;
    drn_off = 0;
    half = ~half;
    pkt_num = (pkt_num + 1) & 8'hff;
    wr_off = 3;
    sz_off = 3;
  endfunction

  function automatic int unsigned chan_len(logic [31:0] g);
    int unsigned sr, code;
    sr = g[11:0];
    code = g[15:12];
    if (code == 0) return (sr >> 1) + 8;
    if (sr == 0) return 4;
    return code * (sr - 1) + 8;
  endfunction

  function automatic void reset_model();
    seg_limit = sbur_pkg::MAX_SEG_RESET;
    half = 0; wr_off = 3; sz_off = 3; pkt_num = 0; phase = PH_SIZE;
    hdr = 0; coll_cnt = 0; blk_left = 0; ch_left = 0; first_ch = 1;
    stamp = 0; drn_off = 0; drn_len = 0;
  endfunction

  function automatic void chan_end();
    phase = (blk_left != 0) ? PH_CHHDR : PH_SIZE;
  endfunction

  function automatic sbur_pkg::rsp_t repack_step(sbur_pkg::req_t r);
    sbur_pkg::rsp_t o;
    int unsigned w1, gs, part, len;
    logic [31:0] gh;
    bit ch_flush, end_flush;
    o = '0;
    if (r.command == CMD_POP) begin
      if (drn_len != 0) begin
        o.out_valid = 1;
        o.out_byte = pstore[(half ? 0 : SB) + (drn_off % SB)];
        drn_off++;
        if (drn_off >= drn_len) begin
          o.out_last = 1; drn_off = 0; drn_len = 0;
        end
      end
      return o;
    end
    w1 = wr_off; ch_flush = 0; gs = 0;
    gh = {hdr[23:0], r.data_byte};
    if (phase == PH_WHOLE || phase == PH_CHBODY) w1++;
    if (phase == PH_CHHDR && coll_cnt == 3 && !r.end_of_data) begin
      gs = chan_len(gh);
      if (gs + 11 <= seg_limit)
        ch_flush = (longint'(wr_off) + gs + (first_ch ? 8 : 0)) > seg_limit;
    end
    end_flush = r.end_of_data && w1 > 11;
    if ((ch_flush || end_flush) && drn_len != 0) return o;
    o.push_taken = 1;
    case (phase)
      PH_SIZE: begin
        hdr = gh; coll_cnt++;
        if (coll_cnt >= 4) begin
          len = hdr; coll_cnt = 0;
          if (!r.end_of_data && len >= 4) begin
            blk_left = len - 4;
            if (longint'(wr_off) + (len - 2) <= seg_limit) begin
              put(wr_off, (len - 2) >> 8); put(wr_off + 1, len - 2);
              wr_off += 2;
              phase = blk_left ? PH_WHOLE : PH_SIZE;
            end else begin
              phase = PH_STAMP; first_ch = 1; stamp = 0;
            end
          end
        end
      end
      PH_WHOLE: begin
        put(wr_off, r.data_byte); wr_off++;
        if (blk_left != 0) blk_left--;
        if (blk_left == 0) phase = PH_SIZE;
      end
      PH_STAMP: begin
        stamp = {stamp[39:0], r.data_byte};
        if (blk_left != 0) blk_left--;
        coll_cnt++;
        if (coll_cnt >= 6) begin coll_cnt = 0; chan_end(); end
      end
      PH_CHHDR: begin
        hdr = gh;
        if (blk_left != 0) blk_left--;
        coll_cnt++;
        if (coll_cnt >= 4 && !r.end_of_data) begin
          coll_cnt = 0;
          if (gs + 11 > seg_limit) begin
            o.block_dropped = 1;
            ch_left = gs - 4;
            if (ch_left != 0) phase = PH_SKIP; else chan_end();
          end else begin
            if (ch_flush) close_payload();
            if (ch_flush || first_ch) begin
              sz_off = wr_off;
              for (int k = 0; k < 6; k++) put(wr_off + 2 + k, 32'(stamp >> (8 * (5 - k))));
              wr_off += 8; first_ch = 0;
            end
            for (int k = 0; k < 4; k++) put(wr_off + k, gh >> (8 * (3 - k)));
            wr_off += 4;
            part = wr_off + gs - 4 - sz_off;
            put(sz_off, part >> 8); put(sz_off + 1, part);
            ch_left = gs - 4;
            if (ch_left != 0) phase = PH_CHBODY; else chan_end();
          end
        end
      end
      PH_CHBODY: begin
        put(wr_off, r.data_byte); wr_off++;
        if (blk_left != 0) blk_left--;
        ch_left--;
        if (ch_left == 0) chan_end();
      end
      default: begin
        if (blk_left != 0) blk_left--;
        if (ch_left != 0) ch_left--;
        if (ch_left == 0) chan_end();
      end
    endcase
    if (r.end_of_data) begin
      phase = PH_SIZE; coll_cnt = 0; hdr = 0; blk_left = 0; ch_left = 0; first_ch = 1;
      if (wr_off > 11) close_payload();
      wr_off = 3; sz_off = 3; pkt_num = 0;
    end
    return o;
  endfunction

  function automatic sbur_pkg::req_t mk(logic c, logic [7:0] b, logic e);
    sbur_pkg::req_t r;
    r.command = c; r.data_byte = b; r.end_of_data = e;
    return r;
  endfunction

  task automatic push_byte(logic [7:0] b, logic e = 1'b0);
    pending_reqs.push_back(mk(CMD_PUSH, b, e));
  endtask

  task automatic push_word(logic [31:0] w);
    for (int k = 3; k >= 0; k--) push_byte(w[8*k +: 8]);
  endtask

  // A block of nch channels; small rates keep channels short. An oversize
  // channel is sized so that with its header overhead it exceeds the limit and is skipped.
  task automatic gen_block(int nch, bit oversize_ch);
    int unsigned lens[$];
    logic [31:0] hdrs[$];
    int unsigned total, sr, code;
    total = 10;
    for (int c = 0; c < nch; c++) begin
      if (oversize_ch && c == 0) begin
        code = 1;
        sr = seg_limit - 8;
      end else begin
        code = $urandom_range(0, 4);
        sr = $urandom_range(0, 20);
        if ($urandom_range(0, 9) == 0) sr = $urandom_range(0, 12'hfff) & 12'h00f;
      end
      hdrs.push_back({16'($urandom_range(0, 16'hffff)), code[3:0], sr[11:0]});
      lens.push_back(chan_len(hdrs[c]));
      total += lens[c];
    end
    push_word(total);
    for (int k = 0; k < 6; k++) push_byte(8'($urandom_range(0, 255)));
    for (int c = 0; c < nch; c++) begin
      push_word(hdrs[c]);
      for (int k = 4; k < lens[c]; k++) push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic pops(int n);
    for (int k = 0; k < n; k++)
      pending_reqs.push_back(mk(CMD_POP, 8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1))));
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_limit(logic [10:0] v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    seg_limit = v;
  endtask

  // queues at least n requests, then an end of data and 30 pops; runs in zero time
  task automatic random_phase(int n);
    int start;
    start = pending_reqs.size();
    while (pending_reqs.size() - start < n) begin
      case ($urandom_range(0, 9))
        0: push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        1: push_word($urandom_range(0, 3));
        2: begin push_byte(8'($urandom_range(0, 255)), 1'b1); pops(20); end
        3, 4: pops($urandom_range(5, 40));
        5: gen_block(1, seg_limit < 11'd256 && $urandom_range(0, 3) == 0);
        default: begin gen_block($urandom_range(1, 4), 1'b0); pops($urandom_range(0, 30)); end
      endcase
    end
    push_byte(8'h00, 1'b1);
    pops(30);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      rsp_ready <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        expected_rsps.push_back(repack_step(pending_reqs.pop_front()));
      end
      if (!(req_valid && !req_ready)) begin
        if (pending_reqs.size() > (req_valid && req_ready ? 0 : 0) && !hold_send &&
            $urandom_range(0, 99) >= send_idle) begin
          req_valid <= 1'b1;
          req <= pending_reqs[0];
        end else begin
          req_valid <= 1'b0;
        end
      end
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    sbur_pkg::rsp_t exp_r;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected response %h", $realtime, rsp);
        errors++;
      end else begin
        exp_r = expected_rsps.pop_front();
        if (rsp.push_taken !== exp_r.push_taken || rsp.out_valid !== exp_r.out_valid ||
            rsp.out_byte !== exp_r.out_byte || rsp.out_last !== exp_r.out_last ||
            rsp.block_dropped !== exp_r.block_dropped) begin
          $display("%0t: mismatch expected %h actual %h", $realtime, exp_r, rsp);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // directed: pop on empty, short block, whole block, end-of-data flushes
    pops(2);
    push_word(32'd2);
    push_word(32'd10);
    for (int k = 0; k < 6; k++) push_byte(8'hff);
    push_byte(8'h00, 1'b1);
    pops(30);
    push_word(32'hffff_ffff);
    push_byte(8'h80, 1'b1);
    wait_drained();
    set_limit(11'd32);
    gen_block(1, 1'b1);
    gen_block(3, 1'b0);
    random_phase(70);
    wait_drained();
    set_limit(11'd2040);
    random_phase(70);
    // sender pauses mid-stream until every response is back
    repeat (150) @(posedge clk);
    hold_send = 1'b1;
    while (req_valid || expected_rsps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    hold_send = 1'b0;
    wait_drained();
    send_idle = 82; recv_idle = 34;
    set_limit(11'd96);
    random_phase(70);
    wait_drained();
    send_idle = 0; recv_idle = 0;
    set_limit(11'd200);
    random_phase(70);
    wait_drained();
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
sv/sbur_pkg.sv
sv/sbur_front.sv
sv/sbur_queue.sv
sv/sbur_back.sv
sv/seismic_block_udp_repacketizer.sv
sv/sbur_checker.sv
bench/seismic_block_udp_repacketizer_tb.sv
